// File: sv/line_follow_pid_steer_macros.svh
// Assertion macros shared by the line follower steering RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LINE_FOLLOW_PID_STEER_MACROS_SVH
`define LINE_FOLLOW_PID_STEER_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define LFPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lfps_pkg.sv
// Types, constants and helper functions for the line follower steering block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lfps_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_P        = 3'd0;
    localparam logic [2:0] REG_GAIN_I        = 3'd1;
    localparam logic [2:0] REG_GAIN_D        = 3'd2;
    localparam logic [2:0] REG_TARGET        = 3'd3;
    localparam logic [2:0] REG_BASE_POWER    = 3'd4;
    localparam logic [2:0] REG_OBSTACLE_THR  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    // Limits used by the controller.
    localparam logic signed [24:0] SUM_LIMIT   = 25'sd8388607;
    localparam logic signed [11:0] FAR_DIST_S  = 12'sd400;
    localparam logic [8:0]         FAR_DIST    = 9'd400;
    localparam logic signed [28:0] POWER_LIMIT = 29'sd100;

    // Configuration registers.
    typedef struct packed {
        logic [17:0]        gain_p;
        logic [17:0]        gain_i;
        logic [17:0]        gain_d;
        logic [6:0]         target_reflection;
        logic signed [7:0]  base_power;
        logic [8:0]         obstacle_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:             18'd32768,
        gain_i:             18'd197,
        gain_d:             18'd524,
        target_reflection:  7'd52,
        base_power:         8'sd50,
        obstacle_threshold: 9'd150
    };

    // One classified request, passed from the front end to the back end.
    typedef struct packed {
        logic signed [7:0]  err;
        logic signed [23:0] sum;
        logic signed [8:0]  derr;
        logic               obstacle;
        logic               stop;
    } entry_t;

    // Divides a Q16 power by 65536 with truncation toward zero, then
    // saturates it to the wheel power range.
    function automatic logic signed [7:0] to_power(input logic signed [44:0] x);
        logic               adj;
        logic signed [28:0] q;
        logic signed [7:0]  p;
        adj = x[44] && (x[15:0] != 16'd0);
        q = $signed(x[44:16]) + $signed({28'd0, adj});
        if (q > POWER_LIMIT)
        begin
            p = 8'(POWER_LIMIT);
        end
        else if (q < -POWER_LIMIT)
        begin
            p = 8'(-POWER_LIMIT);
        end
        else
        begin
            p = q[7:0];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: sv/lfps_front.sv
// Front end: accepts sensor requests, classifies them and keeps the PID state.
// Depends on lfps_pkg.
`default_nettype none

module lfps_front
    import lfps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [6:0]         reflection,
    input  wire logic signed [11:0] distance,
    input  wire logic [9:0]         red,
    input  wire logic [9:0]         green,
    input  wire logic [9:0]         blue,
    input  wire logic               queue_full,
    output logic                    push,
    output entry_t                  push_entry,
    output logic                    halted
);

    logic signed [23:0] error_sum_reg;
    logic signed [23:0] error_sum_next;
    logic signed [7:0]  last_error_reg;
    logic signed [7:0]  last_error_next;
    logic               halted_reg;
    logic               halted_next;

    logic signed [7:0]  err;
    logic signed [24:0] sum_wide;
    logic signed [23:0] sum_sat;
    logic signed [8:0]  derr;
    logic [8:0]         dist_clamped;
    logic [12:0]        blue_x5;
    logic [12:0]        rgb_x2;
    logic [11:0]        rgb_total;
    logic               blue_hit;

    // A request is taken whenever the queue has room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign halted   = halted_reg;

    // Error, saturated integral and difference to the previous error.
    always_comb
    begin
        err      = $signed({1'b0, reflection}) - $signed({1'b0, cfg.target_reflection});
        sum_wide = 25'(error_sum_reg) + 25'(err);
        if (sum_wide > SUM_LIMIT)
        begin
            sum_sat = 24'(SUM_LIMIT);
        end
        else if (sum_wide < -SUM_LIMIT)
        begin
            sum_sat = 24'(-SUM_LIMIT);
        end
        else
        begin
            sum_sat = sum_wide[23:0];
        end
        derr = 9'(err) - 9'(last_error_reg);
    end

    // Distance clamp and the blue ratio test.
    always_comb
    begin
        if (distance <= 12'sd0 || distance > FAR_DIST_S)
        begin
            dist_clamped = FAR_DIST;
        end
        else
        begin
            dist_clamped = distance[8:0];
        end
        blue_x5   = {1'b0, blue, 2'b00} + {3'b000, blue};
        rgb_total = {2'b00, red} + {2'b00, green} + {2'b00, blue};
        rgb_x2    = {rgb_total, 1'b0};
        blue_hit  = blue_x5 > rgb_x2;
    end

    // The PID state freezes once the stop latch is set.
    always_comb
    begin
        error_sum_next  = error_sum_reg;
        last_error_next = last_error_reg;
        halted_next     = halted_reg;
        if (push && !halted_reg)
        begin
            error_sum_next  = sum_sat;
            last_error_next = err;
            halted_next     = blue_hit;
        end
    end

    always_comb
    begin
        push_entry.err      = err;
        push_entry.sum      = sum_sat;
        push_entry.derr     = derr;
        push_entry.obstacle = dist_clamped < cfg.obstacle_threshold;
        push_entry.stop     = halted_reg || blue_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/lfps_queue.sv
// Short queue of classified requests between the front end and the back end.
// Depends on lfps_pkg for the entry type.
`default_nettype none

module lfps_queue
    import lfps_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output logic        not_empty,
    output entry_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: sv/lfps_back.sv
// Back end: PID products, turn sum, wheel powers and the output register.
// Depends on lfps_pkg.
`default_nettype none

module lfps_back
    import lfps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      q_valid,
    input  wire entry_t    q_entry,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic signed [7:0] left_power,
    output logic signed [7:0] right_power,
    output logic           obstacle_seen,
    output logic           blue_stop
);

    // Multiply stage.
    logic               m_valid_reg;
    logic signed [26:0] p_prod_reg;
    logic signed [42:0] i_prod_reg;
    logic signed [27:0] d_prod_reg;
    logic               m_obst_reg;
    logic               m_stop_reg;

    // Turn stage.
    logic               t_valid_reg;
    logic signed [43:0] turn_reg;
    logic               t_obst_reg;
    logic               t_stop_reg;

    // Output stage.
    logic               out_valid_reg;
    logic signed [7:0]  left_reg;
    logic signed [7:0]  right_reg;
    logic               obst_reg;
    logic               stop_reg;

    logic               out_ready;
    logic               t_ready;
    logic               m_ready;
    logic signed [18:0] gp_s;
    logic signed [18:0] gi_s;
    logic signed [18:0] gd_s;
    logic signed [26:0] p_prod_next;
    logic signed [42:0] i_prod_next;
    logic signed [27:0] d_prod_next;
    logic signed [43:0] turn_next;
    logic signed [44:0] base_q;
    logic signed [44:0] left_q;
    logic signed [44:0] right_q;
    logic signed [7:0]  left_next;
    logic signed [7:0]  right_next;

    // Each stage moves on when the stage after it is empty or moving.
    assign out_ready = !out_valid_reg || !out_stall;
    assign t_ready   = !t_valid_reg || out_ready;
    assign m_ready   = !m_valid_reg || t_ready;
    assign pop       = q_valid && m_ready;

    // Gain products; the gains are unsigned Q16.
    assign gp_s        = $signed({1'b0, cfg.gain_p});
    assign gi_s        = $signed({1'b0, cfg.gain_i});
    assign gd_s        = $signed({1'b0, cfg.gain_d});
    assign p_prod_next = 27'(gp_s) * 27'(q_entry.err);
    assign i_prod_next = 43'(gi_s) * 43'(q_entry.sum);
    assign d_prod_next = 28'(gd_s) * 28'(q_entry.derr);

    // Turn is the sum of the three products.
    assign turn_next = 44'(p_prod_reg) + 44'(i_prod_reg) + 44'(d_prod_reg);

    // Wheel powers from the base power and the turn.
    always_comb
    begin
        base_q  = {{21{cfg.base_power[7]}}, cfg.base_power, 16'd0};
        left_q  = base_q - 45'(turn_reg);
        right_q = base_q + 45'(turn_reg);
        if (t_stop_reg)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else
        begin
            left_next  = to_power(left_q);
            right_next = to_power(right_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= q_valid;
            end
            if (t_ready)
            begin
                t_valid_reg <= m_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= t_valid_reg;
            end
        end
    end

    // Stage payloads load only when their stage advances.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_prod_reg <= p_prod_next;
            i_prod_reg <= i_prod_next;
            d_prod_reg <= d_prod_next;
            m_obst_reg <= q_entry.obstacle;
            m_stop_reg <= q_entry.stop;
        end
        if (t_ready && m_valid_reg)
        begin
            turn_reg   <= turn_next;
            t_obst_reg <= m_obst_reg;
            t_stop_reg <= m_stop_reg;
        end
        if (out_ready && t_valid_reg)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            obst_reg  <= t_obst_reg;
            stop_reg  <= t_stop_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_power    = left_reg;
    assign right_power   = right_reg;
    assign obstacle_seen = obst_reg;
    assign blue_stop     = stop_reg;

endmodule

`default_nettype wire

// File: sv/line_follow_pid_steer.sv
// PID steering for a line-following differential drive.
// Input channel: in_valid / in_stall with one sensor sample per request
// (reflection, distance, red, green, blue). Output channel: out_valid /
// out_stall with one result per request (left_power, right_power,
// obstacle_seen, blue_stop). A request is taken at a clock edge where valid
// is high and stall is low.
// Throughput: one request per cycle while in_stall is low. The front end
// updates the integral, previous error and stop latch in the cycle a request
// is taken (until the stop latch is set), so requests may follow each other
// directly. The result passes the queue, then a multiply stage, a turn-sum
// stage and the power/saturation stage that loads the output register.
// When the receiver stalls, the back-end stages and then the queue fill;
// in_stall rises only when the queue is full. A stalled result holds.
// Reset clears the PID state and stop latch, empties all stages and loads
// the default gains, set point, base power and obstacle threshold.
// Configuration is written through cfg_write / cfg_index / cfg_data; it is up
// to the user to write it only while no request is in flight (the block has no check for this).
// Depends on lfps_pkg, lfps_front, lfps_queue, lfps_back and the macro header.
`default_nettype none
`include "line_follow_pid_steer_macros.svh"

module line_follow_pid_steer
    import lfps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [6:0]             reflection,
    input  wire logic signed [11:0]     distance,
    input  wire logic [9:0]             red,
    input  wire logic [9:0]             green,
    input  wire logic [9:0]             blue,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [7:0]           left_power,
    output logic signed [7:0]           right_power,
    output logic                        obstacle_seen,
    output logic                        blue_stop
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    entry_t q_in;
    entry_t q_head;
    logic   halted;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:       cfg_next.gain_p             = cfg_data[17:0];
                REG_GAIN_I:       cfg_next.gain_i             = cfg_data[17:0];
                REG_GAIN_D:       cfg_next.gain_d             = cfg_data[17:0];
                REG_TARGET:       cfg_next.target_reflection  = cfg_data[6:0];
                REG_BASE_POWER:   cfg_next.base_power         = $signed(cfg_data[7:0]);
                REG_OBSTACLE_THR: cfg_next.obstacle_threshold = cfg_data[8:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lfps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .reflection (reflection),
        .distance   (distance),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .queue_full (q_full),
        .push       (q_push),
        .push_entry (q_in),
        .halted     (halted)
    );

    lfps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    lfps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_entry       (q_head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_power    (left_power),
        .right_power   (right_power),
        .obstacle_seen (obstacle_seen),
        .blue_stop     (blue_stop)
    );

    // Once the stop latch is set it stays set until reset.
    `LFPS_ASSERT_NEXT(a_halt_sticky, halted, halted, "stop latch cleared without reset")

    // A stopped result never drives the wheels.
    `LFPS_ASSERT_SAME(a_stop_zero, out_valid && blue_stop,
        left_power == 8'sd0 && right_power == 8'sd0, "wheel power while stopped")

    // Wheel powers stay inside the saturation range.
    `LFPS_ASSERT_SAME(a_power_range, out_valid,
        left_power <= 8'(POWER_LIMIT) && left_power >= 8'(-POWER_LIMIT) &&
        right_power <= 8'(POWER_LIMIT) && right_power >= 8'(-POWER_LIMIT),
        "wheel power outside saturation range")

endmodule

`default_nettype wire
